// ----- sv/cicsh_pkg.sv -----
// Package: types, constants and CRC table function for the case-insensitive string hash
`timescale 1ns / 1ps

package cicsh_pkg;

  typedef logic [15:0] char_t;
  typedef logic [31:0] hash_t;
  typedef logic [7:0]  byte_t;

  localparam hash_t HashPoly  = 32'h04C1_1DB7;
  localparam hash_t Low24Mask = 32'h00FF_FFFF;
  localparam char_t LowerA    = 16'h0061;
  localparam char_t LowerZ    = 16'h007A;
  localparam char_t CaseGap   = 16'h0020;

  // MSB-first CRC table entry: index placed in the top byte, eight shift steps
  function automatic hash_t crc_table_entry(input byte_t idx);
    hash_t c;
    c = {idx, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ HashPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  // One byte of mixing: right shift by a byte, xor in the table entry
  function automatic hash_t mix_byte(input hash_t h, input byte_t b);
    byte_t idx;
    idx = h[7:0] ^ b;
    return ((h >> 8) & Low24Mask) ^ crc_table_entry(idx);
  endfunction

endpackage

// ----- sv/cicsh_mix.sv -----
// Combinational per-character step: ASCII upper-casing and two byte mixes
`timescale 1ns / 1ps

module cicsh_mix (
  input  cicsh_pkg::char_t char_code_i,
  input  cicsh_pkg::hash_t hash_i,
  output cicsh_pkg::hash_t hash_o
);
  import cicsh_pkg::*;

  char_t folded;
  hash_t mid_hash;

  // Fold lower-case ASCII letters onto upper case; pass everything else
  always_comb begin
    if (char_code_i >= LowerA && char_code_i <= LowerZ) begin
      folded = char_code_i - CaseGap;
    end else begin
      folded = char_code_i;
    end
  end

  // Mix the low byte first, then the high byte
  assign mid_hash = mix_byte(hash_i, folded[7:0]);
  assign hash_o   = mix_byte(mid_hash, folded[15:8]);

endmodule

// ----- sv/case_insensitive_crc_string_hash.sv -----
// Top level: case-insensitive CRC-table hash over a stream of 16-bit characters
//
// Takes one UTF-16 code unit per beat and delivers one 32-bit hash beat for
// each string, after the beat flagged last_char_i. Characters stream at one
// per cycle while the input side is not held: a beat sits in the input
// register, where the case fold and the two chained table lookups run
// against the running hash, and the hash of a completed string then waits in
// the output register until taken. The running hash restarts at zero after
// every string. Only a last character meeting a stalled, full output
// register holds the input side.
`timescale 1ns / 1ps

module case_insensitive_crc_string_hash (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cicsh_pkg::char_t char_code_i,
  input  logic             last_char_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cicsh_pkg::hash_t hash_value_o
);
  import cicsh_pkg::*;

  logic  s1_valid_q;
  char_t s1_char_q;
  logic  s1_last_q;
  hash_t run_hash_q, run_hash_d;
  logic  out_valid_q;
  hash_t out_hash_q;

  hash_t next_hash;
  logic  in_fire;
  logic  s1_go;
  logic  out_take;

  // Hash step for the character held in the input register
  cicsh_mix u_mix (
    .char_code_i (s1_char_q),
    .hash_i      (run_hash_q),
    .hash_o      (next_hash)
  );

  // Handshake: a non-last beat always advances; a last beat needs an output slot that is free or being taken
  assign out_take   = out_valid_q && !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Advance the running hash; clear it once a string completes
  always_comb begin
    run_hash_d = run_hash_q;
    if (s1_go) begin
      run_hash_d = s1_last_q ? '0 : next_hash;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_hash_q  <= '0;
    end else begin
      run_hash_q <= run_hash_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the input beat, hold the finished hash
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_code_i;
      s1_last_q <= last_char_i;
    end
    if (s1_go && s1_last_q) begin
      out_hash_q <= next_hash;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

`ifndef NO_ASSERTIONS
  // A completed string leaves the running hash at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |=> run_hash_q == '0)
    else $error("running hash not cleared after last character");

  // A result appears only after a last character has been processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_go && s1_last_q))
    else $error("result raised without a last character");

  // A held input beat keeps its character and does not disturb the hash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_char_q) && $stable(run_hash_q))
    else $error("held input beat changed");

  // A last character is never processed while the output slot stays occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_last_q |-> !out_valid_q || !out_stall_i)
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- tb/cicsh_hash_checker.sv -----
// Checker: predicts the case-insensitive string hash and compares every result beat
`timescale 1ns / 1ps

module cicsh_hash_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  cicsh_pkg::char_t  char_code_i,
  input  logic              last_char_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  cicsh_pkg::hash_t  hash_value_i,
  output int                fail_count_o,
  output int                pending_o
);
  import cicsh_pkg::*;

  hash_t crc_lut [256];
  hash_t running_hash_q = '0;
  hash_t expected_hashes [$];
  int    mismatches = 0;

  // Fill the MSB-first CRC lookup table, one bit-serial division per entry
  initial begin
    hash_t rem;
    for (int i = 0; i < 256; i++) begin
      rem = hash_t'(i) << 24;
      repeat (8) rem = rem[31] ? ((rem << 1) ^ HashPoly) : (rem << 1);
      crc_lut[i] = rem;
    end
  end

  // Fold ASCII lower case up, then mix low byte and high byte into the hash
  function automatic hash_t fold_char_into_hash(input hash_t h, input char_t c);
    char_t folded;
    folded = (c >= LowerA && c <= LowerZ) ? c - CaseGap : c;
    h = (h >> 8) ^ crc_lut[h[7:0] ^ folded[7:0]];
    h = (h >> 8) ^ crc_lut[h[7:0] ^ folded[15:8]];
    return h;
  endfunction

  // Compare result beats against the oldest expected hash; predict on input beats
  always @(posedge clk_i or negedge rst_ni) begin
    hash_t next_hash;
    hash_t want;
    if (!rst_ni) begin
      running_hash_q = '0;
      expected_hashes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_hashes.size() == 0) begin
          mismatches++;
          $display("%0t: hash beat with none pending: expected nothing, got %08h",
                   $time, hash_value_i);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value_i !== want) begin
            mismatches++;
            $display("%0t: hash_value mismatch: expected %08h, got %08h",
                     $time, want, hash_value_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_hash = fold_char_into_hash(running_hash_q, char_code_i);
        if (last_char_i) begin
          expected_hashes.push_back(next_hash);
          running_hash_q = '0;
        end else begin
          running_hash_q = next_hash;
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_hashes.size();
  end

endmodule

// ----- tb/case_insensitive_crc_string_hash_test.sv -----
// Testbench top: drives character strings into the hash block and gives the verdict
`timescale 1ns / 1ps

module case_insensitive_crc_string_hash_test;
  import cicsh_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int RandomItems   = 650;
  localparam int NumDirected   = 21;

  logic  clk        = 1'b0;
  logic  rst_n      = 1'b0;
  logic  in_valid   = 1'b0;
  logic  in_stall;
  char_t char_code  = '0;
  logic  last_char  = 1'b0;
  logic  out_valid;
  logic  out_stall  = 1'b0;
  hash_t hash_value;

  int fail_count;
  int hashes_pending;
  int send_idle_pct = 26;
  int stall_pct     = 87;
  int chars_sent    = 0;
  int quiet_cycles  = 0;

  // Edge cases: zero and all-ones units, letter boundaries, non-ASCII letters,
  // an embedded zero unit, and one word in two mixed-case spellings
  char_t directed_chars [NumDirected] = '{
    16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h0061, 16'h0041, 16'h007A,
    16'h005A, 16'h0060, 16'h007B, 16'h0161, 16'h00E9, 16'h0041, 16'h0000,
    16'h0042, 16'h0061, 16'h0042, 16'h0063, 16'h0041, 16'h0062, 16'h0043};
  logic directed_last [NumDirected] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

  case_insensitive_crc_string_hash dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_code_i  (char_code),
    .last_char_i  (last_char),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hash_value_o (hash_value)
  );

  cicsh_hash_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .char_code_i  (char_code),
    .last_char_i  (last_char),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hash_value_i (hash_value),
    .fail_count_o (fail_count),
    .pending_o    (hashes_pending)
  );

  always #4 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Count cycles without any beat and abort when the block hangs
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle at random with scrambled payload, then hold one character until taken
  task automatic send_char(input char_t c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      char_code <= char_t'($urandom);
      last_char <= 1'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Drop valid and wait until every expected hash has been taken
  task automatic drain_hashes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
  endtask

  // Bias towards letters of both cases so that folding is well exercised
  function automatic char_t random_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return LowerA + char_t'($urandom_range(0, 25));
      3, 4:    return LowerA - CaseGap + char_t'($urandom_range(0, 25));
      5:       return {8'($urandom), 8'(LowerA + $urandom_range(0, 25))};
      6:       return char_t'($urandom_range(16'h0040, 16'h007F));
      7:       return '0;
      default: return char_t'($urandom);
    endcase
  endfunction

  // Mostly short strings, now and then a long one
  task automatic send_random_string();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    for (int k = 0; k < len; k++) begin
      send_char(random_char(), k == len - 1);
    end
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings, then hold off until every hash is back
    for (int i = 0; i < NumDirected; i++) begin
      send_char(directed_chars[i], directed_last[i]);
    end
    drain_hashes();

    // Random strings in three idling phases
    target = chars_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          stall_pct <= 87;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct <= 26;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      target += RandomItems / 3;
      while (chars_sent < target) send_random_string();
      drain_hashes();
    end

    // Let any stray beat surface before the verdict
    repeat (10) @(posedge clk);
    if (fail_count == 0 && hashes_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/cicsh_pkg.sv
sv/cicsh_mix.sv
sv/case_insensitive_crc_string_hash.sv
tb/cicsh_hash_checker.sv
tb/case_insensitive_crc_string_hash_test.sv
